[rtl/core/psd_pkg.sv]
// Shared constants and types for the point to segment distance pipeline.
package psd_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DIST_WIDTH = 50;
   localparam int XI_WIDTH   = 17;
   localparam int UNB_WIDTH  = 48;
   localparam int RSP_WIDTH  = 120;

   localparam logic [XI_WIDTH-1:0]   ONE_FIX  = 17'd65536;
   localparam logic [XI_WIDTH-1:0]   HALF_FIX = 17'd32768;
   localparam logic [UNB_WIDTH-1:0]  UNB_MAX  = {1'b0, {(UNB_WIDTH-1){1'b1}}};
   localparam logic [UNB_WIDTH-1:0]  UNB_MIN  = {1'b1, {(UNB_WIDTH-1){1'b0}}};
   localparam logic [DIST_WIDTH-1:0] DIST_CAP = {DIST_WIDTH{1'b1}};

   // Status of one division result.
   typedef struct packed {
      logic degen;   // segment length is zero
      logic neg;     // projection is negative
      logic sat;     // ratio is out of range
      logic gt;      // projection exceeds the squared length
      logic rem_nz;  // division left a remainder
   } psd_flags_type;

endpackage

[rtl/core/psd_front.sv]
// Difference vectors, lane products and dot product sums (three stages).
module psd_front #(
   parameter int DIM = 3,
   parameter int CW  = 16,
   localparam int DW  = CW + 1,
   localparam int PW  = 2 * DW,
   localparam int L2W = 2 * CW + 3,
   localparam int SW  = 2 * CW + 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [CW-1:0]  pt_i [DIM],
   input  logic signed [CW-1:0]  p1_i [DIM],
   input  logic signed [CW-1:0]  p2_i [DIM],
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [DW-1:0]  w_o  [DIM],
   output logic signed [DW-1:0]  d_o  [DIM],
   output logic [L2W-1:0]        l2_o,
   output logic signed [SW-1:0]  s_o
);
   import psd_pkg::*;

   logic a_valid_ff, b_valid_ff, c_valid_ff;
   logic a_rdy, b_rdy, c_rdy;

   logic signed [DW-1:0] a_w_ff [DIM];
   logic signed [DW-1:0] a_d_ff [DIM];
   logic signed [DW-1:0] b_w_ff [DIM];
   logic signed [DW-1:0] b_d_ff [DIM];
   logic signed [PW-1:0] b_wd_ff [DIM];
   logic signed [PW-1:0] b_dd_ff [DIM];
   logic signed [PW-1:0] b_wd_in [DIM];
   logic signed [PW-1:0] b_dd_in [DIM];
   logic signed [DW-1:0] c_w_ff [DIM];
   logic signed [DW-1:0] c_d_ff [DIM];
   logic [L2W-1:0]       c_l2_ff, c_l2_in;
   logic signed [SW-1:0] c_s_ff, c_s_in;

   assign c_rdy    = !c_valid_ff || out_ready;
   assign b_rdy    = !b_valid_ff || c_rdy;
   assign a_rdy    = !a_valid_ff || b_rdy;
   assign in_ready = a_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_rdy) begin
            a_valid_ff <= in_valid;
         end
         if (b_rdy) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_rdy) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         b_wd_in[i] = a_w_ff[i] * a_d_ff[i];
         b_dd_in[i] = a_d_ff[i] * a_d_ff[i];
      end
   end

   always_comb begin
      c_l2_in = '0;
      c_s_in  = '0;
      for (int i = 0; i < DIM; i++) begin
         c_l2_in = c_l2_in + L2W'($unsigned(b_dd_ff[i]));
         c_s_in  = c_s_in + SW'(b_wd_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy && in_valid) begin
         for (int i = 0; i < DIM; i++) begin
            a_w_ff[i] <= DW'(pt_i[i]) - DW'(p1_i[i]);
            a_d_ff[i] <= DW'(p2_i[i]) - DW'(p1_i[i]);
         end
      end
      if (b_rdy && a_valid_ff) begin
         b_w_ff  <= a_w_ff;
         b_d_ff  <= a_d_ff;
         b_wd_ff <= b_wd_in;
         b_dd_ff <= b_dd_in;
      end
      if (c_rdy && b_valid_ff) begin
         c_w_ff  <= b_w_ff;
         c_d_ff  <= b_d_ff;
         c_l2_ff <= c_l2_in;
         c_s_ff  <= c_s_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign w_o       = c_w_ff;
   assign d_o       = c_d_ff;
   assign l2_o      = c_l2_ff;
   assign s_o       = c_s_ff;

endmodule

[rtl/core/psd_div.sv]
// Pipelined restoring divider: one quotient bit per stage for |s| * 2^16 / l2.
module psd_div #(
   parameter int DIM = 3,
   parameter int CW  = 16,
   localparam int DW  = CW + 1,
   localparam int L2W = 2 * CW + 3,
   localparam int SW  = 2 * CW + 3,
   localparam int SMW = 2 * CW + 2,
   localparam int QB  = psd_pkg::UNB_WIDTH - 1,
   localparam int NW  = QB + L2W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [DW-1:0]   w_i [DIM],
   input  logic signed [DW-1:0]   d_i [DIM],
   input  logic [L2W-1:0]         l2_i,
   input  logic signed [SW-1:0]   s_i,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic signed [DW-1:0]   w_o [DIM],
   output logic signed [DW-1:0]   d_o [DIM],
   output logic [QB-1:0]          quo_o,
   output psd_pkg::psd_flags_type flags_o
);
   import psd_pkg::*;

   logic                 stg_valid_ff [QB+1];
   logic                 stg_rdy      [QB+2];
   logic [L2W-1:0]       stg_rem_ff   [QB+1];
   logic [QB-1:0]        stg_quo_ff   [QB+1];
   logic [SMW-1:0]       stg_mag_ff   [QB+1];
   logic [L2W-1:0]       stg_l2_ff    [QB+1];
   psd_flags_type        stg_flag_ff  [QB+1];
   logic signed [DW-1:0] stg_w_ff     [QB+1][DIM];
   logic signed [DW-1:0] stg_d_ff     [QB+1][DIM];

   logic [SW-1:0]  s_abs;
   logic [SMW-1:0] mag_in;
   logic [NW-1:0]  num;
   logic [L2W-1:0] rem_in;
   psd_flags_type  flag_in;

   assign stg_rdy[QB+1] = out_ready;
   assign in_ready      = stg_rdy[0];

   // Entry stage: sign and magnitude of the projection, and the part of the
   // dividend that lies above the quotient bits. A remainder there that is
   // already at least l2 means the quotient cannot fit.
   always_comb begin
      s_abs   = s_i[SW-1] ? SW'(-s_i) : SW'(s_i);
      mag_in  = s_abs[SMW-1:0];
      num     = NW'(mag_in) << FRAC_BITS;
      rem_in  = num[NW-1:QB];
      flag_in.degen  = (l2_i == '0);
      flag_in.neg    = s_i[SW-1];
      flag_in.sat    = (rem_in >= l2_i);
      flag_in.gt     = !s_i[SW-1] && (L2W'(mag_in) > l2_i);
      flag_in.rem_nz = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[0] && in_valid) begin
         stg_rem_ff[0]  <= rem_in;
         stg_quo_ff[0]  <= '0;
         stg_mag_ff[0]  <= mag_in;
         stg_l2_ff[0]   <= l2_i;
         stg_flag_ff[0] <= flag_in;
         stg_w_ff[0]    <= w_i;
         stg_d_ff[0]    <= d_i;
      end
   end

   for (genvar j = 0; j <= QB; j++) begin : g_valid
      assign stg_rdy[j] = !stg_valid_ff[j] || stg_rdy[j+1];
      always_ff @(posedge clock) begin
         if (reset) begin
            stg_valid_ff[j] <= 1'b0;
         end else if (stg_rdy[j]) begin
            if (j == 0) begin
               stg_valid_ff[j] <= in_valid;
            end else begin
               stg_valid_ff[j] <= stg_valid_ff[(j == 0) ? 0 : j-1];
            end
         end
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_step
      localparam int K = QB - j;
      logic           nbit;
      logic [L2W:0]   trial;
      logic           ge;
      logic [L2W-1:0] rem_next_in;

      if (K >= FRAC_BITS && K - FRAC_BITS < SMW) begin : g_bit
         assign nbit = stg_mag_ff[j-1][K-FRAC_BITS];
      end else begin : g_zero
         assign nbit = 1'b0;
      end

      always_comb begin
         trial       = {stg_rem_ff[j-1], nbit};
         ge          = (trial >= {1'b0, stg_l2_ff[j-1]});
         rem_next_in = ge ? L2W'(trial - {1'b0, stg_l2_ff[j-1]}) : trial[L2W-1:0];
      end

      always_ff @(posedge clock) begin
         if (stg_rdy[j] && stg_valid_ff[j-1]) begin
            stg_rem_ff[j]  <= rem_next_in;
            stg_quo_ff[j]  <= {stg_quo_ff[j-1][QB-2:0], ge};
            stg_mag_ff[j]  <= stg_mag_ff[j-1];
            stg_l2_ff[j]   <= stg_l2_ff[j-1];
            stg_flag_ff[j] <= stg_flag_ff[j-1];
            stg_w_ff[j]    <= stg_w_ff[j-1];
            stg_d_ff[j]    <= stg_d_ff[j-1];
         end
      end
   end

   always_comb begin
      flags_o        = stg_flag_ff[QB];
      flags_o.rem_nz = |stg_rem_ff[QB];
   end

   assign out_valid = stg_valid_ff[QB];
   assign w_o       = stg_w_ff[QB];
   assign d_o       = stg_d_ff[QB];
   assign quo_o     = stg_quo_ff[QB];

endmodule

[rtl/core/psd_dist.sv]
// Clamping of the ratio and the squared distance to the nearest point (six stages).
module psd_dist #(
   parameter int DIM = 3,
   parameter int CW  = 16,
   localparam int DW  = CW + 1,
   localparam int QB  = psd_pkg::UNB_WIDTH - 1,
   localparam int PFW = DW + psd_pkg::XI_WIDTH + 1,
   localparam int EW  = CW + 20,
   localparam int EHW = EW - 1 - psd_pkg::FRAC_BITS,
   localparam int SQW = 2 * EHW,
   localparam int CRW = EHW + psd_pkg::FRAC_BITS,
   localparam int LLW = 2 * psd_pkg::FRAC_BITS,
   localparam int TWR = SQW + psd_pkg::FRAC_BITS + 3,
   localparam int TW  = (TWR > psd_pkg::DIST_WIDTH) ? TWR : psd_pkg::DIST_WIDTH + 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [DW-1:0]               w_i [DIM],
   input  logic signed [DW-1:0]               d_i [DIM],
   input  logic [QB-1:0]                      quo_i,
   input  psd_pkg::psd_flags_type             flags_i,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [psd_pkg::DIST_WIDTH-1:0]     dist_o,
   output logic [psd_pkg::XI_WIDTH-1:0]       xi_o,
   output logic [psd_pkg::UNB_WIDTH-1:0]      unb_o,
   output logic                               degen_o
);
   import psd_pkg::*;

   logic e_valid_ff, f_valid_ff, g_valid_ff, h_valid_ff, i_valid_ff, j_valid_ff;
   logic e_rdy, f_rdy, g_rdy, h_rdy, i_rdy, j_rdy;

   // Result fields travel alongside the distance arithmetic.
   logic [XI_WIDTH-1:0]  xi_e_ff, xi_f_ff, xi_g_ff, xi_h_ff, xi_i_ff, xi_j_ff, xi_e_in;
   logic [UNB_WIDTH-1:0] unb_e_ff, unb_f_ff, unb_g_ff, unb_h_ff, unb_i_ff, unb_j_ff;
   logic [UNB_WIDTH-1:0] unb_e_in;
   logic dg_e_ff, dg_f_ff, dg_g_ff, dg_h_ff, dg_i_ff, dg_j_ff;

   logic signed [DW-1:0]  w_e_ff [DIM];
   logic signed [DW-1:0]  d_e_ff [DIM];
   logic signed [DW-1:0]  w_f_ff [DIM];
   logic signed [PFW-1:0] prod_f_ff [DIM];
   logic signed [PFW-1:0] prod_f_in [DIM];
   logic [EHW-1:0]        eh_g_ff [DIM];
   logic [EHW-1:0]        eh_g_in [DIM];
   logic [FRAC_BITS-1:0]  el_g_ff [DIM];
   logic [FRAC_BITS-1:0]  el_g_in [DIM];
   logic [SQW-1:0]        sq_h_ff [DIM];
   logic [CRW-1:0]        cr_h_ff [DIM];
   logic [LLW-1:0]        ll_h_ff [DIM];
   logic [TW-1:0]         total_i_ff, total_i_in;
   logic                  big_i_ff, big_i_in;
   logic [DIST_WIDTH-1:0] dist_j_ff, dist_j_in;

   logic signed [EW-1:0]  e_val;
   logic [EW-2:0]         e_mag;
   logic [TW-1:0]         hi_sum;
   logic [LLW+1:0]        lo_sum;

   assign j_rdy    = !j_valid_ff || out_ready;
   assign i_rdy    = !i_valid_ff || j_rdy;
   assign h_rdy    = !h_valid_ff || i_rdy;
   assign g_rdy    = !g_valid_ff || h_rdy;
   assign f_rdy    = !f_valid_ff || g_rdy;
   assign e_rdy    = !e_valid_ff || f_rdy;
   assign in_ready = e_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
      end else begin
         if (e_rdy) begin
            e_valid_ff <= in_valid;
         end
         if (f_rdy) begin
            f_valid_ff <= e_valid_ff;
         end
         if (g_rdy) begin
            g_valid_ff <= f_valid_ff;
         end
         if (h_rdy) begin
            h_valid_ff <= g_valid_ff;
         end
         if (i_rdy) begin
            i_valid_ff <= h_valid_ff;
         end
         if (j_rdy) begin
            j_valid_ff <= i_valid_ff;
         end
      end
   end

   // A negative ratio rounds toward minus infinity, so a remainder adds one
   // to the magnitude before the sign is applied.
   always_comb begin
      if (flags_i.degen) begin
         unb_e_in = UNB_WIDTH'(HALF_FIX);
         xi_e_in  = HALF_FIX;
      end else begin
         if (flags_i.sat) begin
            unb_e_in = flags_i.neg ? UNB_MIN : UNB_MAX;
         end else if (flags_i.neg) begin
            unb_e_in = UNB_WIDTH'(-({1'b0, quo_i} + UNB_WIDTH'(flags_i.rem_nz)));
         end else begin
            unb_e_in = {1'b0, quo_i};
         end
         if (flags_i.neg) begin
            xi_e_in = '0;
         end else if (flags_i.gt) begin
            xi_e_in = ONE_FIX;
         end else begin
            xi_e_in = quo_i[XI_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         prod_f_in[i] = $signed({1'b0, xi_e_ff}) * d_e_ff[i];
      end
   end

   // The error vector is split into integer and fraction halves so that its
   // square needs only narrow multipliers.
   always_comb begin
      e_val = '0;
      e_mag = '0;
      for (int i = 0; i < DIM; i++) begin
         e_val      = (EW'(w_f_ff[i]) <<< FRAC_BITS) - EW'(prod_f_ff[i]);
         e_mag      = e_val[EW-1] ? (EW-1)'(-e_val) : e_val[EW-2:0];
         eh_g_in[i] = e_mag[EW-2:FRAC_BITS];
         el_g_in[i] = e_mag[FRAC_BITS-1:0];
      end
   end

   always_comb begin
      hi_sum   = '0;
      lo_sum   = '0;
      big_i_in = 1'b0;
      for (int i = 0; i < DIM; i++) begin
         if ((sq_h_ff[i] >> (DIST_WIDTH - FRAC_BITS)) != '0) begin
            big_i_in = 1'b1;
         end
         hi_sum = hi_sum + (TW'(sq_h_ff[i]) << FRAC_BITS) + (TW'(cr_h_ff[i]) << 1);
         lo_sum = lo_sum + (LLW+2)'(ll_h_ff[i]);
      end
      total_i_in = hi_sum + TW'(lo_sum >> FRAC_BITS);
   end

   always_comb begin
      if (big_i_ff || (total_i_ff > TW'(DIST_CAP))) begin
         dist_j_in = DIST_CAP;
      end else begin
         dist_j_in = total_i_ff[DIST_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (e_rdy && in_valid) begin
         xi_e_ff  <= xi_e_in;
         unb_e_ff <= unb_e_in;
         dg_e_ff  <= flags_i.degen;
         w_e_ff   <= w_i;
         d_e_ff   <= d_i;
      end
      if (f_rdy && e_valid_ff) begin
         xi_f_ff   <= xi_e_ff;
         unb_f_ff  <= unb_e_ff;
         dg_f_ff   <= dg_e_ff;
         w_f_ff    <= w_e_ff;
         prod_f_ff <= prod_f_in;
      end
      if (g_rdy && f_valid_ff) begin
         xi_g_ff  <= xi_f_ff;
         unb_g_ff <= unb_f_ff;
         dg_g_ff  <= dg_f_ff;
         eh_g_ff  <= eh_g_in;
         el_g_ff  <= el_g_in;
      end
      if (h_rdy && g_valid_ff) begin
         xi_h_ff  <= xi_g_ff;
         unb_h_ff <= unb_g_ff;
         dg_h_ff  <= dg_g_ff;
         for (int i = 0; i < DIM; i++) begin
            sq_h_ff[i] <= SQW'(eh_g_ff[i]) * SQW'(eh_g_ff[i]);
            cr_h_ff[i] <= CRW'(eh_g_ff[i]) * CRW'(el_g_ff[i]);
            ll_h_ff[i] <= LLW'(el_g_ff[i]) * LLW'(el_g_ff[i]);
         end
      end
      if (i_rdy && h_valid_ff) begin
         xi_i_ff    <= xi_h_ff;
         unb_i_ff   <= unb_h_ff;
         dg_i_ff    <= dg_h_ff;
         total_i_ff <= total_i_in;
         big_i_ff   <= big_i_in;
      end
      if (j_rdy && i_valid_ff) begin
         xi_j_ff   <= xi_i_ff;
         unb_j_ff  <= unb_i_ff;
         dg_j_ff   <= dg_i_ff;
         dist_j_ff <= dist_j_in;
      end
   end

   assign out_valid = j_valid_ff;
   assign dist_o    = dist_j_ff;
   assign xi_o      = xi_j_ff;
   assign unb_o     = unb_j_ff;
   assign degen_o   = dg_j_ff;

   a_degen_half : assert property (@(posedge clock) disable iff (reset)
      (j_valid_ff && dg_j_ff) |-> (xi_j_ff == HALF_FIX && unb_j_ff == UNB_WIDTH'(HALF_FIX)))
      else $error("degenerate segment without the half parameter");

   a_xi_range : assert property (@(posedge clock) disable iff (reset)
      j_valid_ff |-> (xi_j_ff <= ONE_FIX))
      else $error("clamped parameter above one");

   a_neg_clamp : assert property (@(posedge clock) disable iff (reset)
      (j_valid_ff && !dg_j_ff && unb_j_ff[UNB_WIDTH-1]) |-> (xi_j_ff == '0))
      else $error("negative ratio not clamped to zero");

   a_one_dist : assert property (@(posedge clock) disable iff (reset)
      (e_valid_ff && !dg_e_ff && xi_e_ff == ONE_FIX) |-> !unb_e_ff[UNB_WIDTH-1])
      else $error("clamp at one with a negative ratio");

endmodule

[rtl/core/point_segment_distance.sv]
// Top level of the streaming point to segment squared distance pipeline.
//
//  Channel   Direction  Handshake              Payload
//  req_      in         req_tvalid/req_tready  req_tdata: point, start, end coordinates
//  rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata: dist_sq, xi, xi_unbounded, degenerate
//
// One transaction is accepted per cycle while the pipeline is not stalled; it passes
// 3 + 48 + 6 = 57 register stages. The divider, which resolves one quotient bit per
// stage, accounts for 48 of them.
// Every stage has its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles are squeezed out while the result channel stalls.
// Reset clears only the valid bits.
module point_segment_distance #(
   parameter int DIM         = 3,
   parameter int COORD_WIDTH = 16,
   localparam int REQ_WIDTH  = ((3 * DIM * COORD_WIDTH + 7) / 8) * 8,
   localparam int DW         = COORD_WIDTH + 1,
   localparam int L2W        = 2 * COORD_WIDTH + 3,
   localparam int SW         = 2 * COORD_WIDTH + 3,
   localparam int QB         = psd_pkg::UNB_WIDTH - 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
   input  logic [REQ_WIDTH-1:0]           req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // dist_sq, xi, xi_unbounded, degenerate, zero fill
   output logic [psd_pkg::RSP_WIDTH-1:0]  rsp_tdata
);
   import psd_pkg::*;

   localparam int RSP_PAD = RSP_WIDTH - (DIST_WIDTH + XI_WIDTH + UNB_WIDTH + 1);

   logic signed [COORD_WIDTH-1:0] pt [DIM];
   logic signed [COORD_WIDTH-1:0] p1 [DIM];
   logic signed [COORD_WIDTH-1:0] p2 [DIM];

   logic                 fr_valid, fr_ready;
   logic signed [DW-1:0] fr_w [DIM];
   logic signed [DW-1:0] fr_d [DIM];
   logic [L2W-1:0]       fr_l2;
   logic signed [SW-1:0] fr_s;

   logic                 dv_valid, dv_ready;
   logic signed [DW-1:0] dv_w [DIM];
   logic signed [DW-1:0] dv_d [DIM];
   logic [QB-1:0]        dv_quo;
   psd_flags_type        dv_flags;

   logic [DIST_WIDTH-1:0] dist_sq;
   logic [XI_WIDTH-1:0]   xi;
   logic [UNB_WIDTH-1:0]  xi_unbounded;
   logic                  degenerate;

   for (genvar i = 0; i < DIM; i++) begin : g_unpack
      assign pt[i] = req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
      assign p1[i] = req_tdata[(DIM+i)*COORD_WIDTH +: COORD_WIDTH];
      assign p2[i] = req_tdata[(2*DIM+i)*COORD_WIDTH +: COORD_WIDTH];
   end

   psd_front #(.DIM(DIM), .CW(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pt_i      (pt),
      .p1_i      (p1),
      .p2_i      (p2),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .w_o       (fr_w),
      .d_o       (fr_d),
      .l2_o      (fr_l2),
      .s_o       (fr_s)
   );

   psd_div #(.DIM(DIM), .CW(COORD_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .w_i       (fr_w),
      .d_i       (fr_d),
      .l2_i      (fr_l2),
      .s_i       (fr_s),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .w_o       (dv_w),
      .d_o       (dv_d),
      .quo_o     (dv_quo),
      .flags_o   (dv_flags)
   );

   psd_dist #(.DIM(DIM), .CW(COORD_WIDTH)) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_ready  (dv_ready),
      .w_i       (dv_w),
      .d_i       (dv_d),
      .quo_i     (dv_quo),
      .flags_i   (dv_flags),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .dist_o    (dist_sq),
      .xi_o      (xi),
      .unb_o     (xi_unbounded),
      .degen_o   (degenerate)
   );

   assign rsp_tdata = {{RSP_PAD{1'b0}}, degenerate, xi_unbounded, xi, dist_sq};

endmodule

[test/point_segment_distance_tb.sv]
// Self-checking testbench for the point to segment squared distance pipeline.
`timescale 1ns / 1ps

module point_segment_distance_tb;
   import psd_pkg::*;

   localparam int DIM        = 3;
   localparam int CW         = 16;
   localparam int REQ_WIDTH  = ((3 * DIM * CW + 7) / 8) * 8;
   localparam int WATCHDOG   = 2000;
   localparam int DRAIN      = 80;

   typedef struct packed {
      logic                  degenerate;
      logic [UNB_WIDTH-1:0]  xi_unbounded;
      logic [XI_WIDTH-1:0]   xi;
      logic [DIST_WIDTH-1:0] dist_sq;
   } seg_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0] rsp_tdata;

   seg_result_type expected_results[$];
   int  error_count = 0;
   int  idle_cycles = 0;

   always #2 clock = ~clock;

   point_segment_distance uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Floor of s * 2^16 / l2 for l2 > 0, saturated to the ratio width.
   function automatic logic signed [UNB_WIDTH-1:0] projection_ratio(
         input longint s, input longint l2);
      logic signed [127:0] num;
      logic signed [127:0] q;
      num = 128'(s) <<< FRAC_BITS;
      q = num / 128'(l2);
      if (q * 128'(l2) != num && num < 0) q = q - 1;
      if (q > 128'sd140737488355327) return UNB_MAX;
      if (q < -128'sd140737488355328) return UNB_MIN;
      return q[UNB_WIDTH-1:0];
   endfunction

   function automatic seg_result_type segment_distance(input logic [REQ_WIDTH-1:0] data);
      seg_result_type r;
      longint w[DIM];
      longint d[DIM];
      longint l2, s, e;
      logic [127:0] acc;
      logic signed [UNB_WIDTH-1:0] ratio;
      logic [XI_WIDTH-1:0] xi;
      l2 = 0;
      s = 0;
      acc = '0;
      for (int i = 0; i < DIM; i++) begin
         w[i] = longint'($signed(data[i*CW +: CW])) -
                longint'($signed(data[(DIM+i)*CW +: CW]));
         d[i] = longint'($signed(data[(2*DIM+i)*CW +: CW])) -
                longint'($signed(data[(DIM+i)*CW +: CW]));
         l2 += d[i] * d[i];
         s += w[i] * d[i];
      end
      if (l2 == 0) begin
         xi = HALF_FIX;
         ratio = UNB_WIDTH'(HALF_FIX);
      end else begin
         ratio = projection_ratio(s, l2);
         if (s < 0) xi = '0;
         else if (s > l2) xi = ONE_FIX;
         else xi = ratio[XI_WIDTH-1:0];
      end
      // The square of one error term can exceed 64 bits.
      for (int i = 0; i < DIM; i++) begin
         e = w[i] * 65536 - longint'(xi) * d[i];
         acc += 128'(e) * 128'(e);
      end
      acc = acc >> FRAC_BITS;
      r.dist_sq = (acc > 128'(DIST_CAP)) ? DIST_CAP : acc[DIST_WIDTH-1:0];
      r.xi = xi;
      r.xi_unbounded = ratio;
      r.degenerate = (l2 == 0);
      return r;
   endfunction

   task automatic send_query(input logic [REQ_WIDTH-1:0] data);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(segment_distance(data));
      @(negedge clock);
   endtask

   function automatic logic [REQ_WIDTH-1:0] pack_query(input int c[9]);
      logic [REQ_WIDTH-1:0] v;
      v = '0;
      for (int i = 0; i < 9; i++) v[i*CW +: CW] = c[i][CW-1:0];
      return v;
   endfunction

   function automatic int rand_coord(input int span);
      if (span >= 32768) return int'($signed(16'($urandom)));
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic test_directed();
      int maxc = 32767;
      int minc = -32768;
      send_query(pack_query('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
      send_query(pack_query('{5, -7, 9, 3, 3, 3, 3, 3, 3}));
      send_query(pack_query('{-5, 0, 0, 0, 0, 0, 10, 0, 0}));
      send_query(pack_query('{15, 1, 0, 0, 0, 0, 10, 0, 0}));
      send_query(pack_query('{4, 6, 0, 0, 0, 0, 10, 0, 0}));
      send_query(pack_query('{1, 1, 1, 0, 0, 0, 3, 3, 3}));
      send_query(pack_query('{10, 0, 0, 0, 0, 0, 10, 0, 0}));
      send_query(pack_query('{0, 0, 0, 0, 0, 0, 10, 0, 0}));
      send_query(pack_query('{maxc, maxc, maxc, minc, minc, minc, minc, minc, minc}));
      send_query(pack_query('{maxc, maxc, maxc, minc, minc, minc, minc, minc, minc + 1}));
      send_query(pack_query('{minc, minc, minc, maxc, maxc, maxc, maxc, maxc, maxc - 1}));
      send_query(pack_query('{maxc, minc, maxc, minc, maxc, minc, maxc, minc, maxc}));
      send_query(pack_query('{minc, maxc, minc, maxc, minc, maxc, minc, maxc, minc}));
      send_query(pack_query('{maxc, 0, 0, 0, 0, 0, 1, 0, 0}));
      send_query(pack_query('{minc, 0, 0, 0, 0, 0, 1, 0, 0}));
      send_query(pack_query('{minc, minc, minc, maxc, maxc, maxc, maxc, maxc, maxc}));
      send_query(pack_query('{0, 0, 0, minc, minc, minc, maxc, maxc, maxc}));
   endtask

   task automatic test_random(input int count);
      int c[9];
      int span;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 3))
            0: span = 32768;
            1: span = 1000;
            2: span = 20;
            default: span = 3;
         endcase
         foreach (c[i]) c[i] = rand_coord(span);
         // Coincident end points now and then.
         if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
         send_query(pack_query(c));
      end
   endtask

   task automatic test_drain_pause();
      test_random(20);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      test_random(20);
   endtask

   // Result side: random stall before each transaction, then check.
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = $urandom_range(0, 3);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            error_count++;
         end else begin
            seg_result_type exp_r, got;
            exp_r = expected_results.pop_front();
            got = rsp_tdata[$bits(seg_result_type)-1:0];
            if (got.dist_sq !== exp_r.dist_sq) begin
               $display("%0t: dist_sq expected %0d actual %0d", $time, exp_r.dist_sq, got.dist_sq);
               error_count++;
            end
            if (got.xi !== exp_r.xi) begin
               $display("%0t: xi expected %0d actual %0d", $time, exp_r.xi, got.xi);
               error_count++;
            end
            if (got.xi_unbounded !== exp_r.xi_unbounded) begin
               $display("%0t: xi_unbounded expected %h actual %h", $time,
                        exp_r.xi_unbounded, got.xi_unbounded);
               error_count++;
            end
            if (got.degenerate !== exp_r.degenerate) begin
               $display("%0t: degenerate expected %b actual %b", $time,
                        exp_r.degenerate, got.degenerate);
               error_count++;
            end
         end
         @(negedge clock);
      end
   end

   // Watchdog: cycles with no transaction on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("point_segment_distance test failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300);
      test_drain_pause();
      test_random(340);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("point_segment_distance test passed");
      else
         $display("point_segment_distance test failed");
      $finish;
   end

endmodule

[files.f]
rtl/core/psd_pkg.sv
rtl/core/psd_front.sv
rtl/core/psd_div.sv
rtl/core/psd_dist.sv
rtl/core/point_segment_distance.sv
test/point_segment_distance_tb.sv
